// ----- rtl/core/lc2k_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes, types and the microcode store of the LC-2K executor.
// No dependencies.
package lc2k_pkg;

  localparam int MEM_WORDS = 4096;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam logic [31:0] MEM_LIMIT = 32'(MEM_WORDS);

  // item function codes
  localparam logic [1:0] FN_LOAD = 2'd0;
  localparam logic [1:0] FN_STEP = 2'd1;
  localparam logic [1:0] FN_READ = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_HALT    = 2'd1;
  localparam logic [1:0] ST_FAULT   = 2'd2;
  localparam logic [1:0] ST_STOPPED = 2'd3;

  // opcodes
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_NAND = 3'd1;
  localparam logic [2:0] OP_LW   = 3'd2;
  localparam logic [2:0] OP_SW   = 3'd3;
  localparam logic [2:0] OP_BEQ  = 3'd4;
  localparam logic [2:0] OP_JALR = 3'd5;
  localparam logic [2:0] OP_HALT = 3'd6;
  localparam logic [2:0] OP_NOOP = 3'd7;

  // microcode addresses
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] U_LOAD  = 4'd0;
  localparam logic [UPC_W-1:0] U_READ  = 4'd1;
  localparam logic [UPC_W-1:0] U_READ2 = 4'd2;
  localparam logic [UPC_W-1:0] U_FETCH = 4'd3;
  localparam logic [UPC_W-1:0] U_DECA  = 4'd4;
  localparam logic [UPC_W-1:0] U_DECB  = 4'd5;
  localparam logic [UPC_W-1:0] U_EA    = 4'd6;
  localparam logic [UPC_W-1:0] U_EXEC  = 4'd7;
  localparam logic [UPC_W-1:0] U_MEM   = 4'd8;
  localparam logic [UPC_W-1:0] U_LWB   = 4'd9;
  localparam logic [UPC_W-1:0] U_NOP   = 4'd10;

  // memory action
  localparam logic [2:0] MS_NONE    = 3'd0;
  localparam logic [2:0] MS_WR_ITEM = 3'd1;
  localparam logic [2:0] MS_RD_ITEM = 3'd2;
  localparam logic [2:0] MS_RD_PC   = 3'd3;
  localparam logic [2:0] MS_EA      = 3'd4;

  // datapath latch action
  localparam logic [1:0] LT_NONE  = 2'd0;
  localparam logic [1:0] LT_DEC_A = 2'd1;
  localparam logic [1:0] LT_B     = 2'd2;
  localparam logic [1:0] LT_EA    = 2'd3;

  // sequencing
  localparam logic [2:0] J_NEXT  = 3'd0;
  localparam logic [2:0] J_DONE  = 3'd1;
  localparam logic [2:0] J_FETCH = 3'd2;
  localparam logic [2:0] J_MEMOP = 3'd3;
  localparam logic [2:0] J_MEM   = 3'd4;

  // result kind on finish
  localparam logic [2:0] R_NONE  = 3'd0;
  localparam logic [2:0] R_LOAD  = 3'd1;
  localparam logic [2:0] R_READ  = 3'd2;
  localparam logic [2:0] R_NOP   = 3'd3;
  localparam logic [2:0] R_FETCH = 3'd4;
  localparam logic [2:0] R_EXEC  = 3'd5;
  localparam logic [2:0] R_MEM   = 3'd6;
  localparam logic [2:0] R_LWB   = 3'd7;

  typedef struct packed {
    logic [2:0]       mem;
    logic [1:0]       lat;
    logic [2:0]       jmp;
    logic [2:0]       res;
    logic [UPC_W-1:0] tgt;
  } ctl_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [31:0]       next_pc;
    logic              reg_write_valid;
    logic [2:0]        reg_index;
    logic [31:0]       reg_value;
    logic              mem_write_valid;
    logic [11:0]       mem_write_addr;
    logic [31:0]       read_data;
    logic [31:0]       executed_count;
  } res_t;

  function automatic ctl_t ucode(input logic [UPC_W-1:0] a);
    ctl_t c;
    c = '{mem: MS_NONE, lat: LT_NONE, jmp: J_DONE, res: R_NOP, tgt: U_LOAD};
    case (a)
      U_LOAD:  c = '{mem: MS_WR_ITEM, lat: LT_NONE,  jmp: J_DONE,  res: R_LOAD,  tgt: U_LOAD};
      U_READ:  c = '{mem: MS_RD_ITEM, lat: LT_NONE,  jmp: J_NEXT,  res: R_NONE,  tgt: U_LOAD};
      U_READ2: c = '{mem: MS_NONE,    lat: LT_NONE,  jmp: J_DONE,  res: R_READ,  tgt: U_LOAD};
      U_FETCH: c = '{mem: MS_RD_PC,   lat: LT_NONE,  jmp: J_FETCH, res: R_FETCH, tgt: U_LOAD};
      U_DECA:  c = '{mem: MS_NONE,    lat: LT_DEC_A, jmp: J_NEXT,  res: R_NONE,  tgt: U_LOAD};
      U_DECB:  c = '{mem: MS_NONE,    lat: LT_B,     jmp: J_NEXT,  res: R_NONE,  tgt: U_LOAD};
      U_EA:    c = '{mem: MS_NONE,    lat: LT_EA,    jmp: J_MEMOP, res: R_NONE,  tgt: U_MEM};
      U_EXEC:  c = '{mem: MS_NONE,    lat: LT_NONE,  jmp: J_DONE,  res: R_EXEC,  tgt: U_LOAD};
      U_MEM:   c = '{mem: MS_EA,      lat: LT_NONE,  jmp: J_MEM,   res: R_MEM,   tgt: U_LOAD};
      U_LWB:   c = '{mem: MS_NONE,    lat: LT_NONE,  jmp: J_DONE,  res: R_LWB,   tgt: U_LOAD};
      U_NOP:   c = '{mem: MS_NONE,    lat: LT_NONE,  jmp: J_DONE,  res: R_NOP,   tgt: U_LOAD};
      default: c = '{mem: MS_NONE,    lat: LT_NONE,  jmp: J_DONE,  res: R_NOP,   tgt: U_LOAD};
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/lc2k_ifs.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for items and results of the LC-2K executor.
// No dependencies.
interface lc2k_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [11:0]        word_addr;
  logic signed [31:0] word_data;

  modport source (output valid, func, word_addr, word_data, input ready);
  modport sink   (input valid, func, word_addr, word_data, output ready);
endinterface

interface lc2k_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] next_pc;
  logic               reg_write_valid;
  logic [2:0]         reg_index;
  logic signed [31:0] reg_value;
  logic               mem_write_valid;
  logic [11:0]        mem_write_addr;
  logic signed [31:0] read_data;
  logic [31:0]        executed_count;

  modport source (output valid, status, next_pc, reg_write_valid, reg_index, reg_value,
                  mem_write_valid, mem_write_addr, read_data, executed_count,
                  input ready);
  modport sink   (input valid, status, next_pc, reg_write_valid, reg_index, reg_value,
                  mem_write_valid, mem_write_addr, read_data, executed_count,
                  output ready);
endinterface

// ----- rtl/core/lc2k_instruction_executor.sv -----
`timescale 1ns / 1ps
// LC-2K executor top level: microcode sequencer, register file and datapath.
// Depends on lc2k_pkg, lc2k_ifs and lc2k_ram.
//
// After reset the block sweeps its 4096-word memory to zero, one word per
// cycle, and takes no item until the sweep ends. Each item then runs a short
// microprogram over one single-port memory that does one access per cycle:
// a load writes; a read reads, then returns the word; a step fetches, decodes,
// reads operands, forms the address and executes (lw and sw take the memory
// step instead, lw then write-back; a fetch finding the machine stopped or the
// pc out of range ends there). Items are handled one at a time; a new item is
// taken once the previous one's result sits in the output register, even if
// not yet taken. A finished item holds its last step while the output is full.
module lc2k_instruction_executor
  import lc2k_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  lc2k_in_if.sink   in_ch,
  lc2k_out_if.source out_ch
);

  // sequencer
  logic             busy_r;
  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  logic [UPC_W-1:0] entry;
  ctl_t             cw;
  logic             fin;
  logic             out_free;
  logic             fin_go;
  logic             adv;
  logic             in_xfer;

  // memory clear sweep
  logic              clr_r;
  logic [MEM_AW-1:0] clr_addr_r;

  // item payload
  logic [11:0] waddr_r;
  logic [31:0] wdata_r;

  // architectural state
  logic [31:0] pc_r;
  logic [31:0] cnt_r;
  logic        stop_r;
  logic [31:0] rf_r [8];

  // datapath
  logic [31:0] ir_r;
  logic [31:0] a_r;
  logic [31:0] b_r;
  logic [31:0] ea_r;
  logic [2:0]  rf_raddr;
  logic [31:0] rf_q;
  logic [2:0]  op;
  logic [31:0] imm32;
  logic [31:0] pc1;
  logic        item_ok;
  logic        pc_ok;
  logic        ea_ok;

  // memory port
  logic              ram_we;
  logic              ram_re;
  logic [MEM_AW-1:0] ram_addr;
  logic [31:0]       ram_wd;
  logic [31:0]       ram_q;

  // commit
  res_t        res;
  logic [31:0] pc_nxt;
  logic [31:0] cnt_nxt;
  logic        stop_nxt;
  logic        rf_we;
  logic [2:0]  rf_idx;
  logic [31:0] rf_val;
  logic        wr;
  logic [2:0]  widx;
  logic [31:0] wval;
  logic        bump;

  // output register
  logic out_valid_r;
  res_t out_r;

  lc2k_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wd),
    .rdata (ram_q)
  );

  assign cw       = ucode(upc_r);
  assign op       = ir_r[24:22];
  assign imm32    = {{16{ir_r[15]}}, ir_r[15:0]};
  assign pc1      = pc_r + 32'd1;
  assign item_ok  = 32'(waddr_r) < MEM_LIMIT;
  assign pc_ok    = pc_r < MEM_LIMIT;
  assign ea_ok    = ea_r < MEM_LIMIT;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready = !clr_r && !busy_r;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    case (in_ch.func)
      FN_LOAD: entry = U_LOAD;
      FN_STEP: entry = U_FETCH;
      FN_READ: entry = U_READ;
      default: entry = U_NOP;
    endcase
  end

  // jump resolution
  always_comb begin
    fin     = 1'b0;
    upc_nxt = upc_r + UPC_W'(1);
    case (cw.jmp)
      J_NEXT:  fin = 1'b0;
      J_DONE:  fin = 1'b1;
      J_FETCH: fin = stop_r || !pc_ok;
      J_MEMOP: begin
        if (op == OP_LW || op == OP_SW) begin
          upc_nxt = cw.tgt;
        end
      end
      J_MEM:   fin = !ea_ok || (op == OP_SW);
      default: fin = 1'b1;
    endcase
  end

  assign adv    = !fin || out_free;
  assign fin_go = busy_r && fin && out_free;

  // memory port control
  always_comb begin
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_addr = '0;
    ram_wd   = '0;
    if (clr_r) begin
      ram_we   = 1'b1;
      ram_addr = clr_addr_r;
    end else if (busy_r) begin
      case (cw.mem)
        MS_WR_ITEM: begin
          ram_we   = item_ok && out_free;
          ram_addr = MEM_AW'(32'(waddr_r));
          ram_wd   = wdata_r;
        end
        MS_RD_ITEM: begin
          ram_re   = 1'b1;
          ram_addr = MEM_AW'(32'(waddr_r));
        end
        MS_RD_PC: begin
          ram_re   = 1'b1;
          ram_addr = pc_r[MEM_AW-1:0];
        end
        MS_EA: begin
          ram_addr = ea_r[MEM_AW-1:0];
          ram_wd   = b_r;
          if (op == OP_SW) begin
            ram_we = ea_ok && out_free;
          end else begin
            ram_re = 1'b1;
          end
        end
        default: ram_re = 1'b0;
      endcase
    end
  end

  // register file read port
  assign rf_raddr = (cw.lat == LT_DEC_A) ? ram_q[21:19] : ir_r[18:16];
  assign rf_q     = rf_r[rf_raddr];

  // result and commit values
  always_comb begin
    res          = '0;
    res.status   = ST_OK;
    pc_nxt       = pc_r;
    cnt_nxt      = cnt_r;
    stop_nxt     = stop_r;
    wr           = 1'b0;
    widx         = '0;
    wval         = '0;
    bump         = 1'b0;
    case (cw.res)
      R_LOAD: begin
        if (!item_ok) res.status = ST_FAULT;
      end
      R_READ: begin
        if (item_ok) res.read_data = ram_q;
        else res.status = ST_FAULT;
      end
      R_FETCH: begin
        if (stop_r) begin
          res.status = ST_STOPPED;
        end else begin
          res.status = ST_FAULT;
          stop_nxt   = 1'b1;
        end
      end
      R_EXEC: begin
        pc_nxt = pc1;
        bump   = 1'b1;
        case (op)
          OP_ADD: begin
            wr = 1'b1; widx = ir_r[2:0]; wval = a_r + b_r;
          end
          OP_NAND: begin
            wr = 1'b1; widx = ir_r[2:0]; wval = ~(a_r & b_r);
          end
          OP_BEQ: begin
            if (a_r == b_r) pc_nxt = pc1 + imm32;
          end
          OP_JALR: begin
            wr = 1'b1; widx = ir_r[18:16]; wval = pc1;
            pc_nxt = a_r;
          end
          OP_HALT: begin
            res.status = ST_HALT;
            stop_nxt   = 1'b1;
            bump       = 1'b0;
          end
          default: bump = 1'b1;
        endcase
      end
      R_MEM: begin
        if (!ea_ok) begin
          res.status = ST_FAULT;
          stop_nxt   = 1'b1;
        end else begin
          res.mem_write_valid = 1'b1;
          res.mem_write_addr  = ea_r[11:0];
          res.read_data       = b_r;
          pc_nxt              = pc1;
          bump                = 1'b1;
        end
      end
      R_LWB: begin
        wr = 1'b1; widx = ir_r[18:16]; wval = ram_q;
        pc_nxt = pc1;
        bump   = 1'b1;
      end
      default: res.status = ST_OK;
    endcase
    if (bump && cnt_r != 32'hFFFF_FFFF) begin
      cnt_nxt = cnt_r + 32'd1;
    end
    rf_we  = wr && (widx != 3'd0);
    rf_idx = widx;
    rf_val = wval;
    if (rf_we) begin
      res.reg_write_valid = 1'b1;
      res.reg_index       = widx;
      res.reg_value       = wval;
    end
    res.next_pc        = pc_nxt;
    res.executed_count = cnt_nxt;
  end

  // sequencer and clear sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      upc_r      <= U_NOP;
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + MEM_AW'(1);
        if (clr_addr_r == MEM_AW'(MEM_WORDS - 1)) clr_r <= 1'b0;
      end
      if (in_xfer) begin
        busy_r <= 1'b1;
        upc_r  <= entry;
      end else if (busy_r && adv) begin
        if (fin) busy_r <= 1'b0;
        else upc_r <= upc_nxt;
      end
    end
  end

  // payload and datapath latches
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      waddr_r <= in_ch.word_addr;
      wdata_r <= in_ch.word_data;
    end
    if (busy_r) begin
      case (cw.lat)
        LT_DEC_A: begin
          ir_r <= ram_q;
          a_r  <= rf_q;
        end
        LT_B:    b_r  <= rf_q;
        LT_EA:   ea_r <= a_r + imm32;
        default: ea_r <= ea_r;
      endcase
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      cnt_r  <= '0;
      stop_r <= 1'b0;
      for (int i = 0; i < 8; i++) rf_r[i] <= '0;
    end else if (fin_go) begin
      pc_r   <= pc_nxt;
      cnt_r  <= cnt_nxt;
      stop_r <= stop_nxt;
      if (rf_we) rf_r[rf_idx] <= rf_val;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) out_r <= res;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_r.status;
  assign out_ch.next_pc         = out_r.next_pc;
  assign out_ch.reg_write_valid = out_r.reg_write_valid;
  assign out_ch.reg_index       = out_r.reg_index;
  assign out_ch.reg_value       = out_r.reg_value;
  assign out_ch.mem_write_valid = out_r.mem_write_valid;
  assign out_ch.mem_write_addr  = out_r.mem_write_addr;
  assign out_ch.read_data       = out_r.read_data;
  assign out_ch.executed_count  = out_r.executed_count;

endmodule

// ----- rtl/core/lc2k_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module lc2k_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule
